// File: hdl/assert_macros.svh
// Assertion macros shared by the ring buffer RTL.
// Every check is clocked on the rising edge; ASSERT_CLK is held off during reset, ASSERT_ALWAYS is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that is also evaluated during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/uart_rb_pkg.sv
// Types and constants of the UART ring buffer block.
// Used by the top level; it depends on nothing else.
package uart_rb_pkg;

   // Event codes carried in the request tuser
   typedef enum logic [2:0] {
      OP_RX_BYTE    = 3'd0,
      OP_HOST_READ  = 3'd1,
      OP_HOST_WRITE = 3'd2,
      OP_TX_READY   = 3'd3,
      OP_TX_DONE    = 3'd4
   } op_type;

   // Receiver status bits: parity, overrun, framing
   localparam logic [7:0] RX_ERR_MASK = 8'h1C;

   // Result beat, last field in the lowest bits
   typedef struct packed {
      logic       transmit_mode;
      logic       ready_irq_on;
      logic       overflow_seen;
      logic [6:0] tx_fill;
      logic [5:0] rx_fill;
      logic       write_accepted;
      logic [7:0] send_byte;
      logic       send_valid;
      logic [7:0] read_byte;
      logic       read_valid;
   } rsp_type;

   // What one item leaves behind while its memory read is in flight
   typedef struct packed {
      logic       read_valid;
      logic       send_valid;
      logic       write_accepted;
      logic [5:0] rx_fill;
      logic [6:0] tx_fill;
      logic       overflow_seen;
      logic       ready_irq_on;
      logic       transmit_mode;
   } stage_type;

endpackage

// File: hdl/uart_rb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Stand-alone; no package needed.
module uart_rb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/uart_ring_buffers_with_direction.sv
// UART receive and transmit ring buffers with half-duplex direction control.
// Pipeline: a taken request beat goes into stage 1 while the receive or transmit RAM does its synchronous
// read; the output register then holds the result beat until it is taken.
// Throughput: one item per cycle; a result beat stalled at the output holds off the request side.
// Reset: synchronous, clears pointers, counts and flags; ready interrupt enabled; RAMs not cleared.
module uart_ring_buffers_with_direction #(
   parameter int RX_DEPTH = 64,
   parameter int TX_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // rx_byte[7:0], rx_status[15:8], host_byte[23:16]
   input  logic [2:0]  req_tuser,  // opcode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_valid[0], read_byte[8:1], send_valid[9], send_byte[17:10], write_accepted[18],
   // rx_fill[24:19], tx_fill[31:25], overflow_seen[32], ready_irq_on[33], transmit_mode[34]
   output logic [39:0] rsp_tdata
);
   import uart_rb_pkg::*;
   `include "assert_macros.svh"

   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int RX_CW = $clog2(RX_DEPTH);
   localparam int TX_CW = $clog2(TX_DEPTH + 1);
   localparam logic [RX_AW-1:0] RX_PTR_LAST = RX_AW'(RX_DEPTH - 1);
   localparam logic [TX_AW-1:0] TX_PTR_LAST = TX_AW'(TX_DEPTH - 1);
   localparam logic [RX_CW-1:0] RX_CNT_LAST = RX_CW'(RX_DEPTH - 1);
   localparam logic [TX_CW-1:0] TX_CNT_FULL = TX_CW'(TX_DEPTH);

   // request fields
   logic [7:0] rx_byte;
   logic [7:0] rx_status;
   logic [7:0] host_byte;
   logic       req_accept;

   assign rx_byte    = req_tdata[7:0];
   assign rx_status  = req_tdata[15:8];
   assign host_byte  = req_tdata[23:16];
   assign req_accept = req_tvalid && req_tready;

   // buffer state
   logic [RX_AW-1:0] rx_wr_ptr_ff, rx_wr_ptr_in, rx_rd_ptr_ff, rx_rd_ptr_in;
   logic [RX_CW-1:0] rx_count_ff, rx_count_in;
   logic             rx_overflow_ff, rx_overflow_in;
   logic [TX_AW-1:0] tx_wr_ptr_ff, tx_wr_ptr_in, tx_rd_ptr_ff, tx_rd_ptr_in;
   logic [TX_CW-1:0] tx_count_ff, tx_count_in;
   logic             ready_irq_ff, ready_irq_in;
   logic             driving_line_ff, driving_line_in;

   // pipeline state
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      s1_advance;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   // RAM ports
   logic       rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
   logic [7:0] rx_rd_data, tx_rd_data;

   logic [RX_CW+5:0] rx_fill_wide;
   logic [TX_CW+6:0] tx_fill_wide;

   uart_rb_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_ptr_ff),
      .wr_data (rx_byte),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rd_ptr_ff),
      .rd_data (rx_rd_data)
   );

   uart_rb_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_ptr_ff),
      .wr_data (host_byte),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rd_ptr_ff),
      .rd_data (tx_rd_data)
   );

   // flow: stage 1 moves on when the output register is free or drains
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;

   // event decode and state update
   always_comb begin
      rx_wr_ptr_in    = rx_wr_ptr_ff;
      rx_rd_ptr_in    = rx_rd_ptr_ff;
      rx_count_in     = rx_count_ff;
      rx_overflow_in  = rx_overflow_ff;
      tx_wr_ptr_in    = tx_wr_ptr_ff;
      tx_rd_ptr_in    = tx_rd_ptr_ff;
      tx_count_in     = tx_count_ff;
      ready_irq_in    = ready_irq_ff;
      driving_line_in = driving_line_ff;
      rx_wr_en        = 1'b0;
      rx_rd_en        = 1'b0;
      tx_wr_en        = 1'b0;
      tx_rd_en        = 1'b0;
      s1_in           = s1_ff;

      if (req_accept) begin
         s1_in.read_valid     = 1'b0;
         s1_in.send_valid     = 1'b0;
         s1_in.write_accepted = 1'b0;
         unique case (req_tuser)
            OP_RX_BYTE: begin
               if ((rx_status & RX_ERR_MASK) == 8'h00) begin
                  rx_wr_en     = 1'b1;
                  rx_wr_ptr_in = (rx_wr_ptr_ff == RX_PTR_LAST) ? '0 : rx_wr_ptr_ff + 1'b1;
                  // count wraps to zero on reaching the depth
                  if (rx_count_ff == RX_CNT_LAST) begin
                     rx_count_in    = '0;
                     rx_overflow_in = 1'b1;
                  end else begin
                     rx_count_in = rx_count_ff + 1'b1;
                  end
               end
            end
            OP_HOST_READ: begin
               if (rx_count_ff != '0) begin
                  rx_rd_en         = 1'b1;
                  s1_in.read_valid = 1'b1;
                  rx_rd_ptr_in = (rx_rd_ptr_ff == RX_PTR_LAST) ? '0 : rx_rd_ptr_ff + 1'b1;
                  rx_count_in  = rx_count_ff - 1'b1;
               end
            end
            OP_HOST_WRITE: begin
               if (tx_count_ff != TX_CNT_FULL) begin
                  tx_wr_en             = 1'b1;
                  s1_in.write_accepted = 1'b1;
                  tx_wr_ptr_in = (tx_wr_ptr_ff == TX_PTR_LAST) ? '0 : tx_wr_ptr_ff + 1'b1;
                  tx_count_in     = tx_count_ff + 1'b1;
                  driving_line_in = 1'b1;
                  ready_irq_in    = 1'b1;
               end
            end
            OP_TX_READY: begin
               if (tx_count_ff != '0) begin
                  tx_rd_en         = 1'b1;
                  s1_in.send_valid = 1'b1;
                  tx_rd_ptr_in = (tx_rd_ptr_ff == TX_PTR_LAST) ? '0 : tx_rd_ptr_ff + 1'b1;
                  tx_count_in  = tx_count_ff - 1'b1;
               end else begin
                  ready_irq_in = 1'b0;
               end
            end
            OP_TX_DONE: begin
               driving_line_in = 1'b0;
            end
            default: begin
               // unused codes only report status
            end
         endcase
      end

      // status after this item, low bits of the counts
      rx_fill_wide        = {6'b0, rx_count_in};
      tx_fill_wide        = {7'b0, tx_count_in};
      s1_in.rx_fill       = rx_fill_wide[5:0];
      s1_in.tx_fill       = tx_fill_wide[6:0];
      s1_in.overflow_seen = rx_overflow_in;
      s1_in.ready_irq_on  = ready_irq_in;
      s1_in.transmit_mode = driving_line_in;
   end

   // stage valid and output register
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      rsp_in = rsp_ff;
      if (s1_advance) begin
         rsp_valid_in          = 1'b1;
         rsp_in.read_valid     = s1_ff.read_valid;
         rsp_in.read_byte      = s1_ff.read_valid ? rx_rd_data : 8'h00;
         rsp_in.send_valid     = s1_ff.send_valid;
         rsp_in.send_byte      = s1_ff.send_valid ? tx_rd_data : 8'h00;
         rsp_in.write_accepted = s1_ff.write_accepted;
         rsp_in.rx_fill        = s1_ff.rx_fill;
         rsp_in.tx_fill        = s1_ff.tx_fill;
         rsp_in.overflow_seen  = s1_ff.overflow_seen;
         rsp_in.ready_irq_on   = s1_ff.ready_irq_on;
         rsp_in.transmit_mode  = s1_ff.transmit_mode;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ptr_ff    <= '0;
         rx_rd_ptr_ff    <= '0;
         rx_count_ff     <= '0;
         rx_overflow_ff  <= 1'b0;
         tx_wr_ptr_ff    <= '0;
         tx_rd_ptr_ff    <= '0;
         tx_count_ff     <= '0;
         ready_irq_ff    <= 1'b1;
         driving_line_ff <= 1'b0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rx_wr_ptr_ff    <= rx_wr_ptr_in;
         rx_rd_ptr_ff    <= rx_rd_ptr_in;
         rx_count_ff     <= rx_count_in;
         rx_overflow_ff  <= rx_overflow_in;
         tx_wr_ptr_ff    <= tx_wr_ptr_in;
         tx_rd_ptr_ff    <= tx_rd_ptr_in;
         tx_count_ff     <= tx_count_in;
         ready_irq_ff    <= ready_irq_in;
         driving_line_ff <= driving_line_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff};

   // checks
   `ASSERT_CLK(a_write_sets_tx_mode, clock, reset,
      req_accept && req_tuser == OP_HOST_WRITE && tx_count_ff != TX_CNT_FULL |=> driving_line_ff,
      "accepted host write did not switch to transmit mode")
   `ASSERT_CLK(a_empty_ready_irq_off, clock, reset,
      req_accept && req_tuser == OP_TX_READY && tx_count_ff == '0 |=> !ready_irq_ff,
      "ready event on empty queue left the interrupt enabled")
   `ASSERT_CLK(a_stage_held_on_stall, clock, reset,
      s1_valid_ff && rsp_valid_ff && !rsp_tready |=> s1_valid_ff && $stable(s1_ff),
      "stalled item left stage 1")
   `ASSERT_CLK(a_no_accept_on_stall, clock, reset,
      s1_valid_ff && !s1_advance |-> !req_tready,
      "request taken while stage 1 is blocked")

endmodule
